### rtl/chash_pkg.sv
// Shared types and constants for the chained hash table.
// Item and result structs, command and status codes, controller states.
// No dependencies.
package chash_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 31;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 3;
    localparam int BUCKET_W = 6;
    localparam int CNT_W    = $clog2(KEY_W);

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LEN_RD,
        S_LEN_CHK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

endpackage

### rtl/chash_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module chash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/chained_hash_table.sv
// Chained hash table: bucket = key mod bucket_count, up to CHAIN_DEPTH keys per bucket.
// An insert or an empty chain ends after the remainder loop and the length read; search
// and delete then compare chain entries in turn, and a delete moves later entries down.
// Throughput: one item at a time; busy is low again in the cycle the result is shown.
// Cost set by the 31-step restoring remainder and the single read port of the entry RAM.
// Reset: a clearing pass zeroes the chain lengths of all NUM_BUCKETS buckets, busy high.
// Depends on chash_pkg and chash_ram.
module chained_hash_table #(
    parameter int NUM_BUCKETS = 64,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  chash_pkg::t_item               i_item,
    output logic                           o_done,
    output chash_pkg::t_result             o_result,
    input  logic                           i_cfg_we,
    input  logic [chash_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int MW = $clog2(NUM_BUCKETS + 1);
    localparam int PW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int LW = $clog2(CHAIN_DEPTH + 1);
    localparam int ENT_DEPTH = 2 ** (BW + PW);

    chash_pkg::t_state r_state, n_state;

    logic [chash_pkg::CFG_W-1:0]    r_bucket_count;
    logic                           r_done, n_done;
    chash_pkg::t_result             r_result, n_result;
    logic [BW-1:0]                  r_clr, n_clr;
    logic [chash_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [chash_pkg::KEY_W-1:0]    r_key, n_key;
    logic [chash_pkg::KEY_W-1:0]    r_kshift, n_kshift;
    logic [MW-1:0]                  r_mod, n_mod;
    logic [MW-1:0]                  r_rem, n_rem;
    logic [chash_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [LW-1:0]                  r_len, n_len;

    logic [MW-1:0]                  eff_mod;
    logic [MW:0]                    div_sh;
    logic [BW-1:0]                  bucket;
    logic [LW-1:0]                  pos_p1, pos_p2;
    logic                           accept, div_last, clr_last;
    logic                           is_full, len_zero, match, last, shift_last;

    // length RAM ports
    logic                           len_we;
    logic [BW-1:0]                  len_waddr;
    logic [LW-1:0]                  len_wdata, len_rdata;
    // entry RAM ports
    logic                           ent_we;
    logic [PW-1:0]                  ent_wpos, ent_rpos;
    logic [chash_pkg::KEY_W-1:0]    ent_wdata, ent_rdata;

    assign busy     = (r_state != chash_pkg::S_IDLE);
    assign accept   = start && !busy && (i_item.command != chash_pkg::CMD_NONE);
    assign bucket   = BW'(r_rem);
    assign div_sh   = {r_rem, r_kshift[chash_pkg::KEY_W-1]};
    assign div_last = (r_cnt == '0);
    assign clr_last = (r_clr == BW'(NUM_BUCKETS - 1));
    assign pos_p1   = LW'(r_pos) + LW'(1);
    assign pos_p2   = pos_p1 + LW'(1);
    assign is_full  = (len_rdata >= LW'(CHAIN_DEPTH));
    assign len_zero = (len_rdata == '0);
    assign match    = (ent_rdata == r_key);
    assign last     = (pos_p1 == r_len);
    assign shift_last = (pos_p2 == r_len);

    // a zero count acts as one, a count above the table size saturates
    always_comb begin
        if (r_bucket_count == '0) begin
            eff_mod = MW'(1);
        end else if (32'(r_bucket_count) > NUM_BUCKETS) begin
            eff_mod = MW'(NUM_BUCKETS);
        end else begin
            eff_mod = MW'(r_bucket_count);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chash_pkg::S_CLEAR: begin
                if (clr_last) n_state = chash_pkg::S_IDLE;
            end
            chash_pkg::S_IDLE: begin
                if (accept) n_state = chash_pkg::S_DIV;
            end
            chash_pkg::S_DIV: begin
                if (div_last) n_state = chash_pkg::S_LEN_RD;
            end
            chash_pkg::S_LEN_RD: begin
                n_state = chash_pkg::S_LEN_CHK;
            end
            chash_pkg::S_LEN_CHK: begin
                if (r_cmd == chash_pkg::CMD_INSERT || len_zero) begin
                    n_state = chash_pkg::S_IDLE;
                end else begin
                    n_state = chash_pkg::S_SCAN_RD;
                end
            end
            chash_pkg::S_SCAN_RD: begin
                n_state = chash_pkg::S_SCAN_CMP;
            end
            chash_pkg::S_SCAN_CMP: begin
                if (match && r_cmd == chash_pkg::CMD_DELETE && !last) begin
                    n_state = chash_pkg::S_SHIFT_RD;
                end else if (match || last) begin
                    n_state = chash_pkg::S_IDLE;
                end else begin
                    n_state = chash_pkg::S_SCAN_RD;
                end
            end
            chash_pkg::S_SHIFT_RD: begin
                n_state = chash_pkg::S_SHIFT_WR;
            end
            chash_pkg::S_SHIFT_WR: begin
                if (shift_last) begin
                    n_state = chash_pkg::S_IDLE;
                end else begin
                    n_state = chash_pkg::S_SHIFT_RD;
                end
            end
            default: n_state = chash_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_done    = 1'b0;
        n_result  = r_result;
        n_clr     = r_clr;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_kshift  = r_kshift;
        n_mod     = r_mod;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_len     = r_len;
        len_we    = 1'b0;
        len_waddr = bucket;
        len_wdata = '0;
        ent_we    = 1'b0;
        ent_wpos  = r_pos;
        ent_wdata = r_key;
        ent_rpos  = r_pos;
        unique case (r_state)
            chash_pkg::S_CLEAR: begin
                len_we    = 1'b1;
                len_waddr = r_clr;
                n_clr     = r_clr + BW'(1);
            end
            chash_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_item.command;
                    n_key    = i_item.key;
                    n_kshift = i_item.key;
                    n_mod    = eff_mod;
                    n_rem    = '0;
                    n_cnt    = chash_pkg::CNT_W'(chash_pkg::KEY_W - 1);
                end
            end
            chash_pkg::S_DIV: begin
                // one quotient bit per cycle, restoring form
                if (div_sh >= {1'b0, r_mod}) begin
                    n_rem = MW'(div_sh - {1'b0, r_mod});
                end else begin
                    n_rem = MW'(div_sh);
                end
                n_kshift = {r_kshift[chash_pkg::KEY_W-2:0], 1'b0};
                n_cnt    = r_cnt - chash_pkg::CNT_W'(1);
            end
            chash_pkg::S_LEN_RD: begin
            end
            chash_pkg::S_LEN_CHK: begin
                n_len = len_rdata;
                n_pos = '0;
                n_result.bucket = chash_pkg::BUCKET_W'(bucket);
                if (r_cmd == chash_pkg::CMD_INSERT) begin
                    n_done = 1'b1;
                    if (is_full) begin
                        n_result.status = chash_pkg::ST_FULL;
                    end else begin
                        ent_we    = 1'b1;
                        ent_wpos  = PW'(len_rdata);
                        len_we    = 1'b1;
                        len_wdata = len_rdata + LW'(1);
                        n_result.status = chash_pkg::ST_INSERTED;
                    end
                end else if (len_zero) begin
                    n_done = 1'b1;
                    n_result.status = chash_pkg::ST_NOT_FOUND;
                end
            end
            chash_pkg::S_SCAN_RD: begin
            end
            chash_pkg::S_SCAN_CMP: begin
                if (match && r_cmd == chash_pkg::CMD_SEARCH) begin
                    n_done = 1'b1;
                    n_result.status = chash_pkg::ST_FOUND;
                end else if (match && last) begin
                    n_done    = 1'b1;
                    len_we    = 1'b1;
                    len_wdata = r_len - LW'(1);
                    n_result.status = chash_pkg::ST_DELETED;
                end else if (!match && last) begin
                    n_done = 1'b1;
                    n_result.status = chash_pkg::ST_NOT_FOUND;
                end else if (!match) begin
                    n_pos = r_pos + PW'(1);
                end
            end
            chash_pkg::S_SHIFT_RD: begin
                ent_rpos = r_pos + PW'(1);
            end
            chash_pkg::S_SHIFT_WR: begin
                // close the gap: entry at pos+1 moves down to pos
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                n_pos     = r_pos + PW'(1);
                if (shift_last) begin
                    n_done    = 1'b1;
                    len_we    = 1'b1;
                    len_wdata = r_len - LW'(1);
                    n_result.status = chash_pkg::ST_DELETED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= chash_pkg::S_CLEAR;
            r_bucket_count <= chash_pkg::CFG_RESET;
            r_done         <= 1'b0;
            r_clr          <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_kshift <= n_kshift;
        r_mod    <= n_mod;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_len    <= n_len;
    end

    chash_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BUCKETS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (bucket),
        .o_rdata (len_rdata)
    );

    chash_ram #(
        .WIDTH (chash_pkg::KEY_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr ({bucket, ent_wpos}),
        .i_wdata (ent_wdata),
        .i_raddr ({bucket, ent_rpos}),
        .o_rdata (ent_rdata)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

    // a result only ever follows a finishing step of the controller
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == chash_pkg::S_LEN_CHK ||
                    $past(r_state) == chash_pkg::S_SCAN_CMP ||
                    $past(r_state) == chash_pkg::S_SHIFT_WR))
        else $error("result strobe without a finishing step");

    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == chash_pkg::S_DIV))
        else $error("accepted item did not enter the remainder loop");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chash_pkg::S_LEN_RD) |-> (r_rem < r_mod))
        else $error("bucket index not below modulus");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chash_pkg::S_SCAN_CMP) |-> (LW'(r_pos) < r_len))
        else $error("chain walk beyond chain length");

endmodule
